[rtl/lphm_pkg.sv]
// Shared types and codes for the linear probing hash map.
`default_nettype none
package lphm_pkg;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENTRY_W = 1 + KEY_W + VAL_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One table slot as it is kept in memory.
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;
endpackage
`default_nettype wire

[rtl/lphm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lphm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/linear_probe_hash_map.sv]
// Linear probing hash map: fixed capacity key/value store with probe sequencer.
//
// Input words carry a command (insert/update, lookup, delete), a key and a value.
// Each accepted word yields exactly one output word: status, found value and
// the number of occupied entries after the operation.
// The home slot is key mod TABLE_SIZE. For a power-of-two size this is a bit
// slice; otherwise a reciprocal multiply and correction in state S_MOD derive it.
// The table sits in one RAM with a registered read, so each probed slot takes
// an address state (S_RD) and then a compare state (S_CHK). A delete adds, for
// every entry of the following cluster, one read plus a full re-insert probe
// from that entry's home slot.
// in_tready is high only while the sequencer is idle; one word is in work at
// a time. A finished result waits in the output register; if the receiver
// stalls, the next word may still be taken and worked, and its result is held
// until the output register frees.
// After reset the block clears the table, one slot a cycle, from slot 0 up to
// the last slot, with in_tready low; the entry count resets to zero.
`default_nettype none
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // cmd[1:0], key[33:2], value[65:34], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // status[1:0], found_value[33:2], entry_total[40:34]
);
  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam bit POW2 = ((1 << AW) == TABLE_SIZE);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] SIZE_C = CW'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] SIZE_K = KEY_W'(TABLE_SIZE);
  // Rounded-up reciprocal of the table size for an exact 32-bit quotient.
  localparam logic [63:0] MAGIC_FULL =
    (((64'd1 << AW) - 64'(TABLE_SIZE)) << 32) / 64'(TABLE_SIZE) + 64'd1;
  localparam logic [KEY_W-1:0] MAGIC = MAGIC_FULL[KEY_W-1:0];

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_RD, S_CHK, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_INS, OP_FIND, OP_DEL, OP_WALK, OP_REINS
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [AW-1:0]    pos_r, pos_nxt, walk_pos_r, walk_pos_nxt, clr_r, clr_nxt;
  logic [CW-1:0]    n_r, n_nxt, w_r, w_nxt, cnt_r, cnt_nxt;
  logic [KEY_W-1:0] acc_r, acc_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [2*KEY_W-1:0] mul_full;
  logic [KEY_W-1:0] half_gap, q_calc, rem_full;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [VAL_W-1:0] found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_found_r, out_found_nxt;
  logic [6:0]       out_total_r, out_total_nxt;
  logic [CW+6:0]    cnt_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, pos_next_slot;
  entry_t        ram_wdata, rd_entry;
  logic          in_acc, key_hit;

  lphm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_total_r, out_found_r, out_status_r};
  assign ram_raddr  = pos_r;
  assign key_hit    = (rd_entry.key == key_r);
  assign pos_next_slot = (pos_r == LAST_SLOT) ? '0 : pos_r + AW'(1);
  assign mul_full = {{KEY_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, MAGIC};
  assign half_gap = (key_r - acc_r) >> 1;
  assign q_calc = (acc_r + half_gap) >> (AW - 1);
  assign rem_full = key_r - acc_r * SIZE_K;
  assign cnt_ext = {7'd0, cnt_nxt};

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    pos_nxt = pos_r;
    walk_pos_nxt = walk_pos_r;
    clr_nxt = clr_r;
    n_nxt = n_r;
    w_nxt = w_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    key_nxt = key_r;
    val_nxt = val_r;
    status_nxt = status_r;
    found_nxt = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt = out_found_r;
    out_total_nxt = out_total_r;
    ram_we = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          key_nxt = in_tdata[33:2];
          val_nxt = in_tdata[65:34];
          status_nxt = ST_MISS;
          found_nxt = '0;
          n_nxt = '0;
          step_nxt = 2'd2;
          pos_nxt = in_tdata[AW+1:2];
          unique case (in_tdata[1:0])
            CMD_INSERT: op_nxt = OP_INS;
            CMD_LOOKUP: op_nxt = OP_FIND;
            CMD_DELETE: op_nxt = OP_DEL;
            default:    op_nxt = OP_FIND;
          endcase
          if (in_tdata[1:0] != CMD_INSERT && in_tdata[1:0] != CMD_LOOKUP &&
              in_tdata[1:0] != CMD_DELETE) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = POW2 ? S_RD : S_MOD;
          end
        end
      end
      S_MOD: begin
        // Multiply-high by the reciprocal, fix up the quotient, then take
        // the remainder as key minus quotient times size.
        step_nxt = step_r - 2'd1;
        if (step_r == 2'd2) begin
          acc_nxt = mul_full[2*KEY_W-1:KEY_W];
        end else if (step_r == 2'd1) begin
          acc_nxt = q_calc;
        end else begin
          pos_nxt = rem_full[AW-1:0];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RD;
        pos_nxt = pos_next_slot;
        n_nxt = n_r + CW'(1);
        unique case (op_r) inside
          OP_INS, OP_REINS: begin
            if (!rd_entry.used || key_hit) begin
              ram_we = 1'b1;
              ram_wdata.used = 1'b1;
              ram_wdata.key = key_r;
              ram_wdata.value = val_r;
              if (!rd_entry.used) begin
                cnt_nxt = cnt_r + CW'(1);
              end
              status_nxt = ST_OK;
              pos_nxt = pos_r;
              if (op_r == OP_INS) begin
                state_nxt = S_DONE;
              end else begin
                // Re-insert placed; move on along the cluster.
                w_nxt = w_r + CW'(1);
                op_nxt = OP_WALK;
                pos_nxt = (walk_pos_r == LAST_SLOT) ? '0 : walk_pos_r + AW'(1);
                if (w_r + CW'(1) + CW'(1) >= SIZE_C) begin
                  state_nxt = S_DONE;
                end
              end
            end else if (n_r + CW'(1) == SIZE_C) begin
              status_nxt = (op_r == OP_INS) ? ST_FULL : ST_OK;
              state_nxt = S_DONE;
            end
          end
          OP_FIND, OP_DEL: begin
            if (!rd_entry.used) begin
              state_nxt = S_DONE;
            end else if (key_hit) begin
              status_nxt = ST_OK;
              if (op_r == OP_FIND) begin
                found_nxt = rd_entry.value;
                state_nxt = S_DONE;
              end else begin
                ram_we = 1'b1;
                cnt_nxt = cnt_r - CW'(1);
                w_nxt = '0;
                op_nxt = OP_WALK;
                if (TABLE_SIZE < 2) begin
                  state_nxt = S_DONE;
                end
              end
            end else if (n_r + CW'(1) == SIZE_C) begin
              state_nxt = S_DONE;
            end
          end
          OP_WALK: begin
            if (!rd_entry.used) begin
              state_nxt = S_DONE;
            end else begin
              // Lift the entry out and re-insert it from its home slot.
              ram_we = 1'b1;
              cnt_nxt = cnt_r - CW'(1);
              key_nxt = rd_entry.key;
              val_nxt = rd_entry.value;
              walk_pos_nxt = pos_r;
              op_nxt = OP_REINS;
              n_nxt = '0;
              step_nxt = 2'd2;
              pos_nxt = rd_entry.key[AW-1:0];
              state_nxt = POW2 ? S_RD : S_MOD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt = found_r;
          out_total_nxt = cnt_ext[6:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    pos_r <= pos_nxt;
    walk_pos_r <= walk_pos_nxt;
    n_r <= n_nxt;
    w_r <= w_nxt;
    acc_r <= acc_nxt;
    step_r <= step_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    status_r <= status_nxt;
    found_r <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r <= out_found_nxt;
    out_total_r <= out_total_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SIZE_C) else $error("entry count exceeds table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("second word taken while one is in work");

  a_walk_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && op_r == OP_DEL && rd_entry.used && key_hit) |=>
      (cnt_r == $past(cnt_r) - CW'(1))) else $error("delete hit did not drop the count");
`endif
endmodule
`default_nettype wire

[tb/tb_linear_probe_hash_map.sv]
// Self-checking testbench for the linear probing hash map.
`default_nettype none
module tb_linear_probe_hash_map
  import lphm_pkg::*;
();

  localparam int unsigned SLOTS = 64;
  localparam int unsigned N_RANDOM = 1550;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        has_exp;
    logic [1:0]  status;
    logic [31:0] found;
    logic [6:0]  total;
  } vector_t;

  typedef struct packed {
    logic        typed;
    logic [6:0]  total;
    logic [31:0] found;
    logic [1:0]  status;
  } typed_t;

  typedef struct packed {
    logic        typed;
    logic [6:0]  t_total;
    logic [31:0] t_found;
    logic [1:0]  t_status;
    logic [6:0]  total;
    logic [31:0] found;
    logic [1:0]  status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  // Shadow copy of the table.
  logic        map_used [SLOTS];
  logic [31:0] map_key [SLOTS];
  logic [31:0] map_val [SLOTS];
  int unsigned map_count;

  reply_t      pending_replies[$];
  typed_t      typed_rows[$];
  int unsigned error_count = 0;
  int unsigned word_count = 0;
  int unsigned reply_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned full_hits = 0;
  int unsigned delete_hits = 0;

  linear_probe_hash_map #(.TABLE_SIZE(SLOTS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [1:0] map_insert(logic [31:0] key, logic [31:0] val);
    int unsigned x;
    x = key % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (!map_used[x]) begin
        map_used[x] = 1'b1;
        map_key[x] = key;
        map_val[x] = val;
        map_count++;
        return ST_OK;
      end
      if (map_key[x] == key) begin
        map_val[x] = val;
        return ST_OK;
      end
      x = (x + 1) % SLOTS;
    end
    return ST_FULL;
  endfunction

  function automatic int map_find(logic [31:0] key);
    int unsigned x;
    x = key % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (!map_used[x]) return -1;
      if (map_key[x] == key) return x;
      x = (x + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic reply_t apply_command(logic [1:0] cmd, logic [31:0] key,
                                           logic [31:0] val);
    reply_t r;
    int hit;
    int unsigned x;
    logic [31:0] k, v;
    r = '0;
    r.status = ST_MISS;
    if (cmd == CMD_INSERT) begin
      r.status = map_insert(key, val);
    end else if (cmd == CMD_LOOKUP) begin
      hit = map_find(key);
      if (hit >= 0) begin
        r.status = ST_OK;
        r.found = map_val[hit];
      end
    end else if (cmd == CMD_DELETE) begin
      hit = map_find(key);
      if (hit >= 0) begin
        r.status = ST_OK;
        x = hit;
        map_used[x] = 1'b0;
        map_count--;
        x = (x + 1) % SLOTS;
        // Pull the rest of the cluster out and put it back from its home slot.
        for (int n = 0; n + 1 < SLOTS && map_used[x]; n++) begin
          k = map_key[x];
          v = map_val[x];
          map_used[x] = 1'b0;
          map_count--;
          void'(map_insert(k, v));
          x = (x + 1) % SLOTS;
        end
      end
    end
    r.total = map_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at reply %0d: %s got 0x%0h expected 0x%0h",
             reply_count, what, got, want);
    error_count++;
  endtask

  task automatic send_word(logic [1:0] cmd, logic [31:0] key, logic [31:0] val);
    in_tdata <= {6'd0, val, key, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_with_gap(logic [1:0] cmd, logic [31:0] key, logic [31:0] val,
                               ref int burst);
    int unsigned gap;
    if (burst == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst--;
    send_word(cmd, key, val);
  endtask

  // Predict at acceptance time so the queue is ordered like the block's work.
  always @(posedge clk) begin
    reply_t r;
    typed_t row;
    if (rst_n && in_tvalid && in_tready) begin
      r = apply_command(in_tdata[1:0], in_tdata[33:2], in_tdata[65:34]);
      if (typed_rows.size() != 0) begin
        row = typed_rows.pop_front();
        r.typed = row.typed;
        r.t_status = row.status;
        r.t_found = row.found;
        r.t_total = row.total;
      end
      pending_replies.insert(pending_replies.size(), r);
      word_count++;
      if (r.status == ST_FULL) full_hits++;
      if (in_tdata[1:0] == CMD_DELETE && r.status == ST_OK) delete_hits++;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        $display("unexpected reply word 0x%0h", out_tdata);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[1:0] != want.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        if (out_tdata[33:2] != want.found)
          report_mismatch("found_value", out_tdata[33:2], want.found);
        if (out_tdata[40:34] != want.total)
          report_mismatch("entry_total", 32'(out_tdata[40:34]), 32'(want.total));
        if (want.typed) begin
          if (out_tdata[1:0] != want.t_status)
            report_mismatch("listed status", 32'(out_tdata[1:0]), 32'(want.t_status));
          if (out_tdata[33:2] != want.t_found)
            report_mismatch("listed found_value", out_tdata[33:2], want.t_found);
          if (out_tdata[40:34] != want.t_total)
            report_mismatch("listed entry_total", 32'(out_tdata[40:34]),
                            32'(want.t_total));
        end
      end
    end
  end

  // Receiver is ready for 30 of every 97 replies, and stalls at random otherwise.
  always @(posedge clk) begin
    int unsigned phase;
    phase = reply_count % 97;
    if (phase < 30) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) > 3);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else if (in_tvalid || pending_replies.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("** linear_probe_hash_map: FAILED **");
      $finish;
    end
  end

  vector_t directed[] = '{
    '{CMD_LOOKUP, 32'h0, 32'h0, 1'b1, ST_MISS, 32'h0, 7'd0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_MISS, 32'h0, 7'd0},
    '{CMD_SPARE, 32'h5, 32'h5, 1'b1, ST_MISS, 32'h0, 7'd0},
    '{CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 7'd1},
    '{CMD_LOOKUP, 32'h0, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 7'd1},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OK, 32'h0, 7'd2},
    '{CMD_INSERT, 32'h0, 32'h1234_5678, 1'b0, 0, 0, 0},
    '{CMD_INSERT, 32'h40, 32'hA5A5_A5A5, 1'b0, 0, 0, 0},
    '{CMD_INSERT, 32'h80, 32'h5A5A_5A5A, 1'b0, 0, 0, 0},
    '{CMD_INSERT, 32'h1, 32'h1111, 1'b0, 0, 0, 0},
    '{CMD_DELETE, 32'h0, 32'h0, 1'b0, 0, 0, 0},
    '{CMD_LOOKUP, 32'h80, 32'h0, 1'b0, 0, 0, 0},
    '{CMD_LOOKUP, 32'h1, 32'h0, 1'b0, 0, 0, 0},
    '{CMD_LOOKUP, 32'hFFFF_FFBF, 32'h0, 1'b0, 0, 0, 0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0, 0, 0, 0},
    '{CMD_SPARE, 32'h40, 32'hDEAD_BEEF, 1'b0, 0, 0, 0}
  };

  initial begin
    int burst;
    int unsigned phase_ops;
    logic [1:0] cmd;
    logic [31:0] key, val;
    logic [31:0] key_pool[$];
    typed_t row;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (map_used[i]) map_used[i] = 1'b0;
    map_count = 0;

    // Directed rows: listed expectations are matched to the reply of their word.
    foreach (directed[i]) begin
      row.typed = directed[i].has_exp;
      row.status = directed[i].status;
      row.found = directed[i].found;
      row.total = directed[i].total;
      typed_rows.insert(typed_rows.size(), row);
      send_word(directed[i].cmd, directed[i].key, directed[i].value);
    end

    // Fill the table, hit it when full, then drain it with deletes.
    burst = 0;
    for (int i = 0; i < 70; i++)
      send_with_gap(CMD_INSERT, i * 7 + 32'h100, $urandom(), burst);
    send_with_gap(CMD_LOOKUP, 32'h7777_0000, 0, burst);
    send_with_gap(CMD_INSERT, 32'h100, 32'hCAFE, burst);
    for (int i = 0; i < 70; i++)
      send_with_gap(CMD_DELETE, i * 7 + 32'h100, 0, burst);

    // Words use a colliding key pool, redrawn every 200 words, or a full-range key.
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        key_pool.delete();
        for (int j = 0; j < $urandom_range(8, 90); j++)
          key_pool.insert(key_pool.size(),
                          ($urandom() & 32'hFFFF_FFC0) | $urandom_range(0, 15));
      end
      phase_ops = $urandom_range(0, 99);
      if (phase_ops < 45) cmd = CMD_INSERT;
      else if (phase_ops < 72) cmd = CMD_LOOKUP;
      else if (phase_ops < 98) cmd = CMD_DELETE;
      else cmd = CMD_SPARE;
      key = ($urandom_range(0, 9) == 0) ? $urandom() :
            key_pool[$urandom_range(0, key_pool.size() - 1)];
      val = $urandom();
      send_with_gap(cmd, key, val, burst);
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d words sent, %0d replies checked, %0d deletes with cluster repair,",
             word_count, reply_count, delete_hits);
    $display("%0d inserts refused on a full table", full_hits);
    if (error_count == 0 && pending_replies.size() == 0)
      $display("** linear_probe_hash_map: PASSED **");
    else
      $display("** linear_probe_hash_map: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

[linear_probe_hash_map.f]
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/linear_probe_hash_map.sv
tb/tb_linear_probe_hash_map.sv
